@@ rtl/core/mvbq_pkg.sv @@
// Package for the multi-voice biquad filter.
// Holds the transaction types, the per-voice history type and the fixed-point constants.
// No dependencies.
package mvbq_pkg;

    localparam int SAMPLE_W   = 24;
    localparam int COEF_W     = 24;
    localparam int VOICE_W    = 4;
    localparam int VOICE_CNT  = 1 << VOICE_W;
    localparam int PROD_W     = SAMPLE_W + COEF_W;
    localparam int ACC_W      = PROD_W + 3;
    localparam int RND_W      = ACC_W + 1;
    localparam int FRAC_SHIFT = 20;
    localparam int ROUND_BIAS = 1 << (FRAC_SHIFT - 1);
    localparam int QUOT_W     = RND_W - FRAC_SHIFT;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_in;
        logic signed [COEF_W-1:0]   coef_b0;
        logic signed [COEF_W-1:0]   coef_b1;
        logic signed [COEF_W-1:0]   coef_b2;
        logic signed [COEF_W-1:0]   coef_a1;
        logic signed [COEF_W-1:0]   coef_a2;
        logic [VOICE_W-1:0]         voice;
        logic                       clear;
    } in_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample_out;
        logic                       saturated;
    } out_item_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] past_in_1;
        logic signed [SAMPLE_W-1:0] past_in_2;
        logic signed [SAMPLE_W-1:0] past_out_1;
        logic signed [SAMPLE_W-1:0] past_out_2;
    } history_t;

endpackage

@@ rtl/core/mvbq_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module mvbq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/core/mvbq_datapath.sv @@
// Biquad arithmetic for one transaction: five products, sum, rounding, saturation.
// Also forms the shifted voice history; a clear item zeros both. Depends on mvbq_pkg.
module mvbq_datapath
    import mvbq_pkg::*;
(
    input  in_item_t  item,
    input  history_t  hist,
    output out_item_t result,
    output history_t  hist_next
);

    logic signed [PROD_W-1:0] p_b0;
    logic signed [PROD_W-1:0] p_b1;
    logic signed [PROD_W-1:0] p_b2;
    logic signed [PROD_W-1:0] p_a1;
    logic signed [PROD_W-1:0] p_a2;
    logic signed [ACC_W-1:0]  acc;
    logic signed [RND_W-1:0]  rnd;
    logic signed [QUOT_W-1:0] quot;
    logic                     over_hi;
    logic                     over_lo;
    logic signed [SAMPLE_W-1:0] y;

    assign p_b0 = PROD_W'(item.coef_b0) * PROD_W'(item.sample_in);
    assign p_b1 = PROD_W'(item.coef_b1) * PROD_W'(hist.past_in_1);
    assign p_b2 = PROD_W'(item.coef_b2) * PROD_W'(hist.past_in_2);
    assign p_a1 = PROD_W'(item.coef_a1) * PROD_W'(hist.past_out_1);
    assign p_a2 = PROD_W'(item.coef_a2) * PROD_W'(hist.past_out_2);

    assign acc  = ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2) - ACC_W'(p_a1) - ACC_W'(p_a2);
    assign rnd  = RND_W'(acc) + RND_W'(ROUND_BIAS);
    assign quot = rnd[RND_W-1:FRAC_SHIFT];

    assign over_hi = !quot[QUOT_W-1] && (|quot[QUOT_W-2:SAMPLE_W-1]);
    assign over_lo = quot[QUOT_W-1] && !(&quot[QUOT_W-2:SAMPLE_W-1]);

    always_comb
    begin
        priority if (over_hi)
        begin
            y = SAMPLE_MAX;
        end
        else if (over_lo)
        begin
            y = SAMPLE_MIN;
        end
        else
        begin
            y = quot[SAMPLE_W-1:0];
        end

        if (item.clear)
        begin
            result    = '0;
            hist_next = '0;
        end
        else
        begin
            result.sample_out    = y;
            result.saturated     = over_hi || over_lo;
            hist_next.past_in_1  = item.sample_in;
            hist_next.past_in_2  = hist.past_in_1;
            hist_next.past_out_1 = y;
            hist_next.past_out_2 = hist.past_out_1;
        end
    end

endmodule

@@ rtl/core/multi_voice_biquad_filter.sv @@
// Top level of the multi-voice biquad filter (direct form I, shared by all voices).
// Depends on mvbq_pkg, mvbq_ram and mvbq_datapath.
//
// The filter accepts one transaction per clock cycle, from any mix of voices, while the
// result channel does not stall. Each transaction waits in the stage register and its
// result in the result register; the cycle time is set by the five 24x24 multiplies,
// the adder and the saturation that sit between the two. Voice history lives in a RAM
// with one entry per voice, read when the transaction is accepted; the last history
// written is forwarded so that a voice may repeat in consecutive cycles. Per-voice
// valid bits make the history read as zero after reset, so no clearing pass is needed.
module multi_voice_biquad_filter
    import mvbq_pkg::*;
#(
    parameter int NUM_VOICES = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      sample_valid,
    output logic      sample_ready,
    input  in_item_t  sample_item,
    output logic      result_valid,
    input  logic      result_ready,
    output out_item_t result_item
);

    localparam int VIDX_W = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

    logic [VIDX_W-1:0] voice_map [VOICE_CNT];

    logic              accept;
    logic              advance;
    logic [VIDX_W-1:0] rd_vidx;

    logic              s1_vld_reg;
    logic              s1_vld_next;
    in_item_t          s1_item_reg;
    logic [VIDX_W-1:0] s1_vidx_reg;

    logic              out_vld_reg;
    logic              out_vld_next;
    out_item_t         out_item_reg;

    logic [NUM_VOICES-1:0] hvalid_reg;
    logic                  byp_vld_reg;
    logic [VIDX_W-1:0]     byp_vidx_reg;
    history_t              byp_hist_reg;

    history_t          ram_hist;
    history_t          hist_cur;
    history_t          hist_new;
    out_item_t         result;

    for (genvar g = 0; g < VOICE_CNT; g++)
    begin : g_vmap
        assign voice_map[g] = VIDX_W'(g % NUM_VOICES);
    end

    assign rd_vidx      = voice_map[sample_item.voice];
    assign advance      = s1_vld_reg && (!out_vld_reg || result_ready);
    assign sample_ready = !s1_vld_reg || advance;
    assign accept       = sample_valid && sample_ready;

    assign s1_vld_next  = accept || (s1_vld_reg && !advance);
    assign out_vld_next = advance || (out_vld_reg && !result_ready);

    mvbq_ram #(
        .WIDTH ($bits(history_t)),
        .DEPTH (NUM_VOICES)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (advance),
        .wr_addr (s1_vidx_reg),
        .wr_data (hist_new),
        .rd_en   (accept),
        .rd_addr (rd_vidx),
        .rd_data (ram_hist)
    );

    always_comb
    begin
        if (byp_vld_reg && (byp_vidx_reg == s1_vidx_reg))
        begin
            hist_cur = byp_hist_reg;
        end
        else if (hvalid_reg[s1_vidx_reg])
        begin
            hist_cur = ram_hist;
        end
        else
        begin
            hist_cur = '0;
        end
    end

    mvbq_datapath u_datapath (
        .item      (s1_item_reg),
        .hist      (hist_cur),
        .result    (result),
        .hist_next (hist_new)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            hvalid_reg  <= '0;
            byp_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg  <= s1_vld_next;
            out_vld_reg <= out_vld_next;
            if (advance)
            begin
                hvalid_reg[s1_vidx_reg] <= 1'b1;
                byp_vld_reg             <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= sample_item;
            s1_vidx_reg <= rd_vidx;
        end
        if (advance)
        begin
            out_item_reg <= result;
            byp_vidx_reg <= s1_vidx_reg;
            byp_hist_reg <= hist_new;
        end
    end

    assign result_valid = out_vld_reg;
    assign result_item  = out_item_reg;

endmodule

@@ rtl/core/mvbq_checker.sv @@
// Port-level checker for the multi-voice biquad filter, bound to the top level.
// Depends on mvbq_pkg.
module mvbq_checker
    import mvbq_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      sample_valid,
    input logic      sample_ready,
    input logic      result_valid,
    input logic      result_ready,
    input out_item_t result_item
);

    logic [1:0] pend_reg;
    logic [1:0] pend_next;
    logic       in_xact;
    logic       out_xact;

    assign in_xact  = sample_valid && sample_ready;
    assign out_xact = result_valid && result_ready;

    always_comb
    begin
        pend_next = pend_reg;
        if (in_xact && !out_xact)
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (out_xact && !in_xact)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // At most two transactions are in flight: one in the stage register, one at the output.
    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg != 2'd3)
        else $error("more than two transactions in flight");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pend_reg != 2'd0))
        else $error("result shown with no transaction pending");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> result_valid)
        else $error("input stalled while the output is empty");

    a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_item.saturated) |->
            ((result_item.sample_out == SAMPLE_MAX) || (result_item.sample_out == SAMPLE_MIN)))
        else $error("saturated result is not at a range limit");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_item)))
        else $error("stalled result changed");

endmodule

bind multi_voice_biquad_filter mvbq_checker u_mvbq_checker (.*);
